// File: hw/rtl/pcts_pkg.sv
// Shared types and constants for the counter-based task scheduler.
// Used by pcts_cell, pcts_ctrl and the top level; no dependencies.
package pcts_pkg;

    localparam int TASK_COUNT = 8;
    localparam int TASK_W     = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int IDX_IN_W   = 3;
    localparam int CNT_W      = 16;
    localparam int PRI_W      = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN1,
        ST_SCAN2,
        ST_DONE
    } t_state;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic              load;
        logic              dec;
        logic              recomp;
        logic [TASK_W-1:0] idx;
        logic [CNT_W-1:0]  counter;
        logic [PRI_W-1:0]  prio;
        logic              runnable;
    } t_cell_cmd;

    // best candidate handed down the chain
    typedef struct packed {
        logic [TASK_W-1:0] idx;
        logic [CNT_W-1:0]  cnt;
    } t_cand;

    typedef logic [TASK_COUNT-1:0][CNT_W-1:0] t_cnt_vec;

endpackage

// File: hw/rtl/pcts_cell.sv
// One task slot: counter, priority, runnable and present flags, plus the
// registered max-candidate stage of the scan chain. Depends on pcts_pkg.
module pcts_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pcts_pkg::TASK_W-1:0] i_cell_idx,
    input  pcts_pkg::t_cell_cmd       i_cmd,
    input  pcts_pkg::t_cand           i_cand,
    output pcts_pkg::t_cand           o_cand,
    output logic [pcts_pkg::CNT_W-1:0] o_counter
);
    import pcts_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [PRI_W-1:0] r_pri;
    logic             r_run;
    logic             r_pres;
    t_cand            r_cand;
    t_cand            n_cand;
    logic             hit;
    logic             take_own;

    assign hit      = (i_cmd.idx == i_cell_idx);
    // strict compare: an equal count from a higher slot stays ahead
    assign take_own = r_pres && r_run && (r_cnt > i_cand.cnt);

    always_comb begin
        n_cand = i_cand;
        if (take_own) begin
            n_cand.idx = i_cell_idx;
            n_cand.cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pri  <= '0;
            r_run  <= 1'b0;
            r_pres <= 1'b0;
            r_cand <= '0;
        end else begin
            r_cand <= n_cand;
            if (i_cmd.load && hit) begin
                r_cnt  <= i_cmd.counter;
                r_pri  <= i_cmd.prio;
                r_run  <= i_cmd.runnable;
                r_pres <= 1'b1;
            end else if (i_cmd.dec && hit) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end else if (i_cmd.recomp && r_pres) begin
                r_cnt <= (r_cnt >> 1) + CNT_W'(r_pri);
            end
        end
    end

    assign o_cand    = r_cand;
    assign o_counter = r_cnt;

endmodule

// File: hw/rtl/pcts_ctrl.sv
// Sequencer: takes stream words, drives loads, decrements and recomputes
// into the cells, waits for the scan chain to settle, forms the result.
// Depends on pcts_pkg.
module pcts_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pcts_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pcts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  pcts_pkg::t_cand               i_best,
    input  pcts_pkg::t_cnt_vec            i_counters,
    output pcts_pkg::t_cell_cmd           o_cell_cmd
);
    import pcts_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic                r_cmd;
    logic [IDX_IN_W-1:0] r_idx;
    logic [CNT_W-1:0]    r_lcnt;
    logic [PRI_W-1:0]    r_lpri;
    logic                r_lrun;
    logic [TASK_W-1:0]   r_cur;
    logic [TASK_W-1:0]   r_prev;
    logic                r_resched;
    logic                r_recomp;
    logic                r_none;
    logic [TASK_W-1:0]   r_wait;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [CNT_W-1:0]    cur_cnt;
    logic                load_ok;
    logic                need_sched;
    logic                dec_ok;
    logic                wait_done;
    logic                found;
    logic                out_free;
    logic                fire_out;
    logic                accept;

    assign cur_cnt    = i_counters[r_cur];
    assign load_ok    = (r_idx != '0) && (int'(r_idx) < TASK_COUNT);
    assign need_sched = (r_cur == '0) || (cur_cnt <= CNT_W'(1));
    assign dec_ok     = (r_cur != '0) && (cur_cnt != '0);
    assign wait_done  = (r_wait == '0);
    assign found      = (i_best.idx != '0);
    assign out_free   = !r_out_valid || m_axis_tready;
    assign accept     = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_EXEC;
            ST_EXEC: begin
                if (r_cmd == CMD_TICK && need_sched) n_state = ST_SCAN1;
                else                                 n_state = ST_DONE;
            end
            ST_SCAN1: begin
                if (wait_done) n_state = found ? ST_DONE : ST_SCAN2;
            end
            ST_SCAN2: if (wait_done) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cell_cmd          = '0;
        o_cell_cmd.idx      = TASK_W'(r_idx);
        o_cell_cmd.counter  = r_lcnt;
        o_cell_cmd.prio     = r_lpri;
        o_cell_cmd.runnable = r_lrun;
        s_axis_tready       = 1'b0;
        fire_out            = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EXEC: begin
                if (r_cmd == CMD_LOAD) begin
                    o_cell_cmd.load = load_ok;
                end else begin
                    o_cell_cmd.dec = dec_ok;
                    o_cell_cmd.idx = r_cur;
                end
            end
            ST_SCAN1: o_cell_cmd.recomp = wait_done && !found;
            ST_SCAN2: ;
            ST_DONE:  fire_out = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_prev      <= '0;
            r_resched   <= 1'b0;
            r_recomp    <= 1'b0;
            r_none      <= 1'b0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_prev    <= r_cur;
                r_resched <= 1'b0;
                r_recomp  <= 1'b0;
                r_none    <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: ;
                ST_EXEC: begin
                    r_resched <= (r_cmd == CMD_TICK) && need_sched;
                    r_wait    <= TASK_W'(TASK_COUNT - 1);
                end
                ST_SCAN1: begin
                    if (!wait_done) begin
                        r_wait <= r_wait - TASK_W'(1);
                    end else if (found) begin
                        r_cur <= i_best.idx;
                    end else begin
                        r_recomp <= 1'b1;
                        r_wait   <= TASK_W'(TASK_COUNT - 1);
                    end
                end
                ST_SCAN2: begin
                    if (!wait_done)  r_wait <= r_wait - TASK_W'(1);
                    else if (found)  r_cur  <= i_best.idx;
                    else             r_none <= 1'b1;
                end
                ST_DONE: ;
                default: ;
            endcase
            if (fire_out)           r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // input and result payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= s_axis_tuser;
            r_idx  <= s_axis_tdata[2:0];
            r_lcnt <= s_axis_tdata[18:3];
            r_lpri <= s_axis_tdata[26:19];
            r_lrun <= s_axis_tdata[27];
        end
        if (fire_out) begin
            r_out_data <= {1'b0, cur_cnt, r_none, r_recomp, r_resched,
                           (r_cur != r_prev), IDX_IN_W'(r_cur)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: hw/rtl/priority_counter_task_scheduler_core.sv
// Counter-based task scheduler: top level, chain of task cells plus controller.
// A load or a tick that needs no rescheduling runs no scan; a rescheduling tick
// runs one scan, then a recompute and a second scan if no runnable task is found.
// One word in flight; the scan time is set by the candidate chain crossing
// TASK_COUNT-1 cell registers. Synchronous active-low reset clears all tasks.
module priority_counter_task_scheduler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] task_index, [18:3] load_counter, [26:19] load_priority,
    // [27] load_runnable, [31:28] zero
    input  logic [31:0] s_axis_tdata,
    // [0] cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] running_task, [3] switched, [4] rescheduled, [5] recomputed,
    // [6] none_runnable, [22:7] running_counter, [23] zero
    output logic [23:0] m_axis_tdata
);
    import pcts_pkg::*;

    t_cell_cmd cell_cmd;
    t_cand     cand [1:TASK_COUNT];
    t_cnt_vec  counters;

    assign cand[TASK_COUNT] = '0;
    // idle slot holds no counter
    assign counters[0] = '0;

    for (genvar g = 1; g < TASK_COUNT; g++) begin : g_cell
        pcts_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (TASK_W'(g)),
            .i_cmd      (cell_cmd),
            .i_cand     (cand[g+1]),
            .o_cand     (cand[g]),
            .o_counter  (counters[g])
        );
    end

    pcts_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_best        (cand[1]),
        .i_counters    (counters),
        .o_cell_cmd    (cell_cmd)
    );

endmodule

// File: hw/rtl/pcts_checker.sv
// Port-level checks for the task scheduler, bound to the top level.
// Depends only on the top-level ports.
module pcts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic [23:0] m_axis_tdata
);

    // one word in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted back to back");

    a_switch_needs_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[4])
        else $error("switch without scheduling pass");

    a_recomp_needs_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4])
        else $error("recompute without scheduling pass");

    a_none_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[5] && !m_axis_tdata[3])
        else $error("none_runnable inconsistent with recompute or switch");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid after reset");

endmodule

bind priority_counter_task_scheduler_core pcts_checker u_pcts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
);
